[src/stft_pkg.sv]
// shared types, constants and rom functions for the stft analysis block
package stft_pkg;

   localparam int SAMPLE_W = 16;
   localparam int BIN_W    = 24;
   localparam int IDX_W    = 6;
   localparam int COEF_W   = 18;
   localparam int PROD_W   = BIN_W + COEF_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int RND_W    = ACC_W - 16;
   localparam int SUM_W    = RND_W + 1;

   typedef enum logic [1:0] {
      MAC_HOLD,
      MAC_SET,
      MAC_ADD,
      MAC_SUB
   } mac_op_type;

   typedef struct packed {
      mac_op_type               op;
      logic signed [BIN_W-1:0]  op_a;
      logic signed [COEF_W-1:0] op_b;
   } mac_ctl_type;

   localparam logic signed [COEF_W-1:0] QCOS [0:16] = '{
      18'sd65536, 18'sd65220, 18'sd64277, 18'sd62714, 18'sd60547, 18'sd57798,
      18'sd54491, 18'sd50660, 18'sd46341, 18'sd41576, 18'sd36410, 18'sd30893,
      18'sd25080, 18'sd19024, 18'sd12785, 18'sd6424,  18'sd0
   };

   function automatic logic signed [COEF_W-1:0] rom_cos(input logic [IDX_W-1:0] q);
      logic [IDX_W-1:0]         k;
      logic                     neg;
      logic signed [COEF_W-1:0] r;
      if (q <= 6'd16) begin
         k = q;
         neg = 1'b0;
      end else if (q <= 6'd32) begin
         k = 6'd32 - q;
         neg = 1'b1;
      end else if (q <= 6'd48) begin
         k = q - 6'd32;
         neg = 1'b1;
      end else begin
         k = 6'(7'd64 - 7'(q));
         neg = 1'b0;
      end
      r = QCOS[k[4:0]];
      return neg ? -r : r;
   endfunction

   function automatic logic signed [COEF_W-1:0] rom_sin(input logic [IDX_W-1:0] q);
      return rom_cos(q + 6'd48);
   endfunction

   function automatic logic [15:0] hann_w(input logic [IDX_W-1:0] q);
      logic signed [18:0] t;
      t = 19'sd65537 - 19'(rom_cos(q));
      t = t >>> 1;
      if (t > 19'sd65535) return 16'hFFFF;
      return t[15:0];
   endfunction

   function automatic logic signed [BIN_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
      if (v > SUM_W'(24'sh7FFFFF)) return 24'sh7FFFFF;
      if (v < -SUM_W'(25'sd8388608)) return 24'sh800000;
      return v[BIN_W-1:0];
   endfunction

endpackage

[src/stft_mac.sv]
// shared multiply accumulate unit with registered product and q16 rounding
module stft_mac (
   input  logic                             clock,
   input  stft_pkg::mac_ctl_type            ctl,
   output logic signed [stft_pkg::RND_W-1:0] rnd
);
   import stft_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  acc_bias;

   always_comb begin
      prod_in = PROD_W'(ctl.op_a) * PROD_W'(ctl.op_b);
      unique case (ctl.op)
         MAC_SET: acc_in = ACC_W'(prod_ff);
         MAC_ADD: acc_in = acc_ff + ACC_W'(prod_ff);
         MAC_SUB: acc_in = acc_ff - ACC_W'(prod_ff);
         default: acc_in = acc_ff;
      endcase
      acc_bias = acc_ff + ACC_W'(32768);
      rnd = $signed(acc_bias[ACC_W-1:16]);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

[src/stft_analysis_hann_fft.sv]
// top level: sample history, fft work memory and frame sequencer
//
//  channel | dir | ports                                         | beat
//  req     | in  | req_valid req_stall req_sample                | one sample
//  rsp     | out | rsp_valid rsp_stall rsp_bin_index rsp_real_part| one bin
//          |     | rsp_imag_part rsp_last_bin                    |
//
//  a sample that completes no hop is stored and leaves the block ready for the next
//  a hop-completing sample starts a frame: windowing of the N history samples,
//  N/2*log2(N) butterflies, then output of bins 0 to N/2; windowing and
//  butterflies all go through the single multiply accumulate unit
//  req_stall is high for the whole frame; rsp_stall holds the current bin
//  synchronous reset clears history write pointer and fill count, hop count and sequencer
module stft_analysis_hann_fft #(
   parameter int FFT_SIZE = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [stft_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [stft_pkg::IDX_W-1:0]           rsp_bin_index,
   output logic signed [stft_pkg::BIN_W-1:0]    rsp_real_part,
   output logic signed [stft_pkg::BIN_W-1:0]    rsp_imag_part,
   output logic                                rsp_last_bin
);
   import stft_pkg::*;

   localparam int LOG   = $clog2(FFT_SIZE);
   localparam int HOP   = FFT_SIZE / 2;
   localparam int HOP_W = LOG - 1;
   localparam int STG_W = $clog2(LOG);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WIN  = 4'b0010,
      ST_BFLY = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       step_ff, step_in;
   logic [LOG-1:0]   cnt_ff, cnt_in;
   logic [STG_W-1:0] stage_ff, stage_in;
   logic [HOP_W-1:0] hop_ff, hop_in;
   logic [LOG-1:0]   wptr_ff, wptr_in;
   logic [LOG:0]     fill_ff, fill_in;

   logic signed [SAMPLE_W-1:0] hist [FFT_SIZE];
   logic signed [SAMPLE_W-1:0] hist_x_ff;
   logic                       hist_ok_ff;
   logic [LOG-1:0]             hist_addr;
   logic                       hist_rd;

   logic [2*BIN_W-1:0] work [FFT_SIZE];
   logic [2*BIN_W-1:0] rda_ff, rdb_ff;
   logic               rda_en, rdb_en, wr_en;
   logic [LOG-1:0]     rda_addr, wr_addr;
   logic [2*BIN_W-1:0] wr_data;

   logic signed [RND_W-1:0] tr_ff, tr_in, ti_ff, ti_in;
   logic signed [BIN_W-1:0] ar, ai, br, bi;
   logic [LOG-1:0]          hmask, jj, ia, ib, rev;
   logic [IDX_W-1:0]        tw_k;
   logic signed [COEF_W-1:0] tw_c, tw_s;
   logic signed [BIN_W-1:0] win_x;
   logic signed [RND_W-1:0] rnd;
   mac_ctl_type             mac_ctl;
   logic                    req_acc;

   stft_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .rnd   (rnd)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      hmask = LOG'((1 << stage_ff) - 1);
      jj    = cnt_ff & hmask;
      ia    = LOG'((cnt_ff >> stage_ff) << (stage_ff + 1)) | jj;
      ib    = ia | (LOG'(1) << stage_ff);
      tw_k  = 6'(jj) << (5 - int'(stage_ff));
      tw_c  = rom_cos(tw_k);
      tw_s  = rom_sin(tw_k);
      for (int b = 0; b < LOG; b++) rev[b] = cnt_ff[LOG-1-b];
      ar    = $signed(rda_ff[2*BIN_W-1:BIN_W]);
      ai    = $signed(rda_ff[BIN_W-1:0]);
      br    = $signed(rdb_ff[2*BIN_W-1:BIN_W]);
      bi    = $signed(rdb_ff[BIN_W-1:0]);
      win_x = hist_ok_ff ? BIN_W'(hist_x_ff) : '0;
      hist_addr = wptr_ff + cnt_ff;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      stage_in = stage_ff;
      hop_in   = hop_ff;
      wptr_in  = wptr_ff;
      fill_in  = fill_ff;
      tr_in    = tr_ff;
      ti_in    = ti_ff;
      hist_rd  = 1'b0;
      rda_en   = 1'b0;
      rdb_en   = 1'b0;
      rda_addr = ia;
      wr_en    = 1'b0;
      wr_addr  = ia;
      wr_data  = '0;
      mac_ctl.op   = MAC_HOLD;
      mac_ctl.op_a = br;
      mac_ctl.op_b = tw_c;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               wptr_in = wptr_ff + 1'b1;
               if (fill_ff != (LOG+1)'(FFT_SIZE)) fill_in = fill_ff + 1'b1;
               if (hop_ff == HOP_W'(HOP - 1)) begin
                  hop_in   = '0;
                  state_in = ST_WIN;
                  cnt_in   = '0;
                  step_in  = '0;
               end else begin
                  hop_in = hop_ff + 1'b1;
               end
            end
         end
         ST_WIN: begin
            mac_ctl.op_a = win_x;
            mac_ctl.op_b = COEF_W'(hann_w(6'(cnt_ff) << (IDX_W - LOG)));
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               3'd0: hist_rd = 1'b1;
               3'd2: mac_ctl.op = MAC_SET;
               3'd3: begin
                  wr_en   = 1'b1;
                  wr_addr = rev;
                  wr_data = {rnd[BIN_W-1:0], {BIN_W{1'b0}}};
                  step_in = '0;
                  if (cnt_ff == LOG'(FFT_SIZE - 1)) begin
                     state_in = ST_BFLY;
                     cnt_in   = '0;
                     stage_in = '0;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_BFLY: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               3'd0: begin
                  rda_en = 1'b1;
                  rdb_en = 1'b1;
               end
               3'd1: begin
                  mac_ctl.op_a = br;
                  mac_ctl.op_b = tw_c;
               end
               3'd2: begin
                  mac_ctl.op   = MAC_SET;
                  mac_ctl.op_a = bi;
                  mac_ctl.op_b = tw_s;
               end
               3'd3: begin
                  mac_ctl.op   = MAC_ADD;
                  mac_ctl.op_a = bi;
                  mac_ctl.op_b = tw_c;
               end
               3'd4: begin
                  mac_ctl.op   = MAC_SET;
                  mac_ctl.op_a = br;
                  mac_ctl.op_b = tw_s;
                  tr_in = rnd;
               end
               3'd5: mac_ctl.op = MAC_SUB;
               3'd6: begin
                  ti_in   = rnd;
                  wr_en   = 1'b1;
                  wr_addr = ia;
                  wr_data = {sat24(SUM_W'(ar) + SUM_W'(tr_ff)),
                             sat24(SUM_W'(ai) + SUM_W'(rnd))};
               end
               default: begin
                  wr_en   = 1'b1;
                  wr_addr = ib;
                  wr_data = {sat24(SUM_W'(ar) - SUM_W'(tr_ff)),
                             sat24(SUM_W'(ai) - SUM_W'(ti_ff))};
                  step_in = '0;
                  if (cnt_ff == LOG'(HOP - 1)) begin
                     cnt_in = '0;
                     if (stage_ff == STG_W'(LOG - 1)) state_in = ST_OUT;
                     else stage_in = stage_ff + 1'b1;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
            endcase
         end
         ST_OUT: begin
            rda_addr = cnt_ff;
            if (step_ff == 3'd0) begin
               rda_en  = 1'b1;
               step_in = 3'd1;
            end else if (!rsp_stall) begin
               step_in = '0;
               if (cnt_ff == LOG'(HOP)) begin
                  state_in = ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         cnt_ff   <= '0;
         stage_ff <= '0;
         hop_ff   <= '0;
         wptr_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         stage_ff <= stage_in;
         hop_ff   <= hop_in;
         wptr_ff  <= wptr_in;
         fill_ff  <= fill_in;
      end
      tr_ff <= tr_in;
      ti_ff <= ti_in;
   end

   // history ring, unwritten slots read as zero through the fill count
   always_ff @(posedge clock) begin
      if (req_acc) hist[wptr_ff] <= req_sample;
      if (hist_rd) begin
         hist_x_ff  <= hist[hist_addr];
         hist_ok_ff <= (fill_ff == (LOG+1)'(FFT_SIZE)) || ({1'b0, hist_addr} < fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) work[wr_addr] <= wr_data;
      if (rda_en) rda_ff <= work[rda_addr];
      if (rdb_en) rdb_ff <= work[ib];
   end

   assign rsp_valid     = (state_ff == ST_OUT) && (step_ff == 3'd1);
   assign rsp_bin_index = 6'(cnt_ff);
   assign rsp_real_part = ar;
   assign rsp_imag_part = ai;
   assign rsp_last_bin  = (cnt_ff == LOG'(HOP));

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a bin is pending");

   a_last_is_nyquist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_bin) |-> (rsp_bin_index == 6'(HOP)))
      else $error("last flag off the nyquist bin");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (LOG+1)'(FFT_SIZE))
      else $error("history fill count overran");

   a_frame_after_hop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in == ST_WIN) |-> req_acc)
      else $error("frame started without a sample");

endmodule
